// File: src/ccs_pkg.sv
// Shared widths, codes, command/status types for the correction statistics core.
package ccs_pkg;

    // Field and result widths
    localparam int DATA_W  = 32;
    localparam int NAME_W  = 24;
    localparam int NODE_W  = 25;
    localparam int OUT_W   = 31;
    localparam int SEL_W   = 4;

    // Accumulator sizing (log2 of the node count limit)
    localparam int MAX_NODES_LOG2 = 24;
    localparam int CNT_W   = MAX_NODES_LOG2;
    localparam int SUM_W   = DATA_W + CNT_W;

    // Reference magnitude in unsigned Q32.32, and the shared divider
    localparam int REF_W   = 64;
    localparam int DIV_W   = 64;
    localparam int STEP_W  = 7;
    localparam int A100_W  = DATA_W + 7;
    localparam logic [STEP_W-1:0] PCT_STEPS = STEP_W'(32);
    localparam logic [STEP_W-1:0] AVG_STEPS = STEP_W'(SUM_W);
    localparam logic [REF_W-1:0]  REF_MIN   = REF_W'(4);
    localparam logic [6:0]        PCT_SCALE = 7'd100;

    // APB port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_VAR_SEL = REG_IDX_W'(0);

    // Reference variable codes
    localparam logic [SEL_W-1:0] SEL_U    = 4'd0;
    localparam logic [SEL_W-1:0] SEL_V    = 4'd1;
    localparam logic [SEL_W-1:0] SEL_H    = 4'd2;
    localparam logic [SEL_W-1:0] SEL_S    = 4'd3;
    localparam logic [SEL_W-1:0] SEL_K    = 4'd4;
    localparam logic [SEL_W-1:0] SEL_D    = 4'd5;
    localparam logic [SEL_W-1:0] SEL_C    = 4'd6;
    localparam logic [SEL_W-1:0] SEL_QB   = 4'd7;
    localparam logic [SEL_W-1:0] SEL_DZ   = 4'd8;
    localparam logic [SEL_W-1:0] SEL_UH   = 4'd9;
    localparam logic [SEL_W-1:0] SEL_VH   = 4'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic prep;
        logic calc_ref;
        logic pct_start;
        logic p_sat;
        logic p_load;
        logic ratio_upd;
        logic avg_abs_start;
        logic avg_abs_store;
        logic avg_ratio_start;
        logic avg_ratio_store;
        logic emit;
    } ccs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic ref_ok;
        logic pct_sat;
        logic div_done;
        logic last;
    } ccs_status_t;

endpackage

// File: src/correction_change_statistics_core.sv
// Top level: APB register, controller and datapath of the correction statistics core.
// One request at a time. A node with no relative change passes IDLE, PREP, REF and CHK;
// one whose percent saturates adds PUPD; any other with a relative change also waits in
// PDIV for the 32-step shared divider. The last node adds the two 56-step average
// divisions (ADIV, RDIV), plus any wait in EMIT for the output register to free up.
// Reset (rst_n, asynchronous, low) clears the statistics, nodes to -1, selector to 0.
module correction_change_statistics_core
    import ccs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] correction,
    input  logic signed [DATA_W-1:0] vel_u,
    input  logic signed [DATA_W-1:0] vel_v,
    input  logic signed [DATA_W-1:0] surface,
    input  logic signed [DATA_W-1:0] bed_level,
    input  logic signed [DATA_W-1:0] turb_k,
    input  logic signed [DATA_W-1:0] turb_d,
    input  logic signed [DATA_W-1:0] concentration,
    input  logic signed [DATA_W-1:0] bedload,
    input  logic signed [DATA_W-1:0] bed_change,
    input  logic [NAME_W-1:0]        node_name,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OUT_W-1:0]         max_abs,
    output logic signed [NODE_W-1:0] max_abs_node,
    output logic [OUT_W-1:0]         avg_abs,
    output logic [OUT_W-1:0]         max_pct,
    output logic signed [NODE_W-1:0] max_pct_node,
    output logic [OUT_W-1:0]         avg_pct
);

    logic [SEL_W-1:0]     var_sel_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    ccs_cmd_t             cmd;
    ccs_status_t          status;

    // Register access
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_VAR_SEL) ? APB_DATA_W'(var_sel_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_sel_reg <= '0;
        end
        else if (cfg_wr && (reg_idx == REG_VAR_SEL))
        begin
            var_sel_reg <= pwdata[SEL_W-1:0];
        end
    end

    ccs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ccs_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .variable_select (var_sel_reg),
        .correction      (correction),
        .vel_u           (vel_u),
        .vel_v           (vel_v),
        .surface         (surface),
        .bed_level       (bed_level),
        .turb_k          (turb_k),
        .turb_d          (turb_d),
        .concentration   (concentration),
        .bedload         (bedload),
        .bed_change      (bed_change),
        .node_name       (node_name),
        .last            (last),
        .max_abs         (max_abs),
        .max_abs_node    (max_abs_node),
        .avg_abs         (avg_abs),
        .max_pct         (max_pct),
        .max_pct_node    (max_pct_node),
        .avg_pct         (avg_pct)
    );

endmodule

// File: src/ccs_div.sv
// Shared restoring divider, one quotient bit per cycle.
module ccs_div
    import ccs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  rem_init,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIV_W-1:0]  divisor,
    input  logic [STEP_W-1:0] steps,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W-1:0]  q_reg;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;

    // One shift-subtract step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: src/ccs_ctrl.sv
// Sequencing state machine for the correction statistics core.
module ccs_ctrl
    import ccs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  ccs_status_t status,
    output ccs_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_PREP = 10'b00_0000_0010,
        S_REF  = 10'b00_0000_0100,
        S_CHK  = 10'b00_0000_1000,
        S_PDIV = 10'b00_0001_0000,
        S_PUPD = 10'b00_0010_0000,
        S_AABS = 10'b00_0100_0000,
        S_ADIV = 10'b00_1000_0000,
        S_RDIV = 10'b01_0000_0000,
        S_EMIT = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_REF;
            end
            S_REF:
            begin
                cmd.calc_ref = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                priority if (!status.ref_ok)
                begin
                    state_next = status.last ? S_AABS : S_IDLE;
                end
                else if (status.pct_sat)
                begin
                    cmd.p_sat  = 1'b1;
                    state_next = S_PUPD;
                end
                else
                begin
                    cmd.pct_start = 1'b1;
                    state_next    = S_PDIV;
                end
            end
            S_PDIV:
            begin
                if (status.div_done)
                begin
                    cmd.p_load = 1'b1;
                    state_next = S_PUPD;
                end
            end
            S_PUPD:
            begin
                cmd.ratio_upd = 1'b1;
                state_next    = status.last ? S_AABS : S_IDLE;
            end
            S_AABS:
            begin
                cmd.avg_abs_start = 1'b1;
                state_next        = S_ADIV;
            end
            S_ADIV:
            begin
                if (status.div_done)
                begin
                    cmd.avg_abs_store   = 1'b1;
                    cmd.avg_ratio_start = 1'b1;
                    state_next          = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (status.div_done)
                begin
                    cmd.avg_ratio_store = 1'b1;
                    state_next          = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result request valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/ccs_dp.sv
// Datapath: magnitudes, reference value, running statistics and result register.
module ccs_dp
    import ccs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ccs_cmd_t                 cmd,
    output ccs_status_t              status,
    input  logic [SEL_W-1:0]         variable_select,
    input  logic signed [DATA_W-1:0] correction,
    input  logic signed [DATA_W-1:0] vel_u,
    input  logic signed [DATA_W-1:0] vel_v,
    input  logic signed [DATA_W-1:0] surface,
    input  logic signed [DATA_W-1:0] bed_level,
    input  logic signed [DATA_W-1:0] turb_k,
    input  logic signed [DATA_W-1:0] turb_d,
    input  logic signed [DATA_W-1:0] concentration,
    input  logic signed [DATA_W-1:0] bedload,
    input  logic signed [DATA_W-1:0] bed_change,
    input  logic [NAME_W-1:0]        node_name,
    input  logic                     last,
    output logic [OUT_W-1:0]         max_abs,
    output logic signed [NODE_W-1:0] max_abs_node,
    output logic [OUT_W-1:0]         avg_abs,
    output logic [OUT_W-1:0]         max_pct,
    output logic signed [NODE_W-1:0] max_pct_node,
    output logic [OUT_W-1:0]         avg_pct
);

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic [DIV_W-1:0] x);
        return (x[DIV_W-1:OUT_W] != '0) ? {OUT_W{1'b1}} : x[OUT_W-1:0];
    endfunction

    // Captured request
    logic [DATA_W-1:0]  corr_reg;
    logic [DATA_W-1:0]  surf_reg;
    logic [DATA_W-1:0]  bed_reg;
    logic [DATA_W-1:0]  fld_reg;
    logic [NAME_W-1:0]  name_reg;
    logic               last_reg;
    logic [DATA_W-1:0]  fld_sel;

    // Magnitudes
    logic [DATA_W-1:0]  a_reg;
    logic [DATA_W:0]    h_reg;
    logic [DATA_W-1:0]  f_reg;
    logic [DATA_W:0]    h_diff;

    // Reference and scaled correction
    logic [REF_W-1:0]   ref_reg;
    logic [REF_W-1:0]   ref_next;
    logic [A100_W-1:0]  a100_reg;
    logic [2*DATA_W:0]  prod;
    logic [DATA_W-1:0]  p_reg;

    // Statistics
    logic [DATA_W-1:0]  best_abs_reg;
    logic [NODE_W-1:0]  best_abs_node_reg;
    logic [SUM_W-1:0]   sum_abs_reg;
    logic [CNT_W-1:0]   count_abs_reg;
    logic [DATA_W-1:0]  best_ratio_reg;
    logic [NODE_W-1:0]  best_ratio_node_reg;
    logic [SUM_W-1:0]   sum_ratio_reg;
    logic [CNT_W-1:0]   count_ratio_reg;
    logic [OUT_W-1:0]   avg_abs_q_reg;
    logic [OUT_W-1:0]   avg_ratio_q_reg;

    // Result register
    logic [OUT_W-1:0]   max_abs_reg;
    logic [NODE_W-1:0]  max_abs_node_reg;
    logic [OUT_W-1:0]   avg_abs_reg;
    logic [OUT_W-1:0]   max_pct_reg;
    logic [NODE_W-1:0]  max_pct_node_reg;
    logic [OUT_W-1:0]   avg_pct_reg;

    // Divider hookup
    logic               div_start;
    logic [DIV_W-1:0]   div_rem;
    logic [DIV_W-1:0]   div_dvd;
    logic [DIV_W-1:0]   div_dsr;
    logic [STEP_W-1:0]  div_steps;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    // Field picked by the reference selector
    always_comb
    begin
        unique case (variable_select)
            SEL_U, SEL_UH: fld_sel = vel_u;
            SEL_V, SEL_VH: fld_sel = vel_v;
            SEL_K:         fld_sel = turb_k;
            SEL_D:         fld_sel = turb_d;
            SEL_C:         fld_sel = concentration;
            SEL_QB:        fld_sel = bedload;
            SEL_DZ:        fld_sel = bed_change;
            default:       fld_sel = '0;
        endcase
    end

    // Depth S - z, 33 bits
    always_comb
    begin
        h_diff = {surf_reg[DATA_W-1], surf_reg} - {bed_reg[DATA_W-1], bed_reg};
    end

    // Reference magnitude in Q32.32
    always_comb
    begin
        prod = h_reg * f_reg;
        unique case (variable_select)
            SEL_U, SEL_V, SEL_K, SEL_D, SEL_C, SEL_QB, SEL_DZ:
                ref_next = {16'b0, f_reg, 16'b0};
            SEL_H, SEL_S:
                ref_next = {15'b0, h_reg, 16'b0};
            SEL_UH, SEL_VH:
                ref_next = prod[REF_W-1:0];
            default:
                ref_next = '0;
        endcase
    end

    // Request capture and per-node arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            corr_reg <= correction;
            surf_reg <= surface;
            bed_reg  <= bed_level;
            fld_reg  <= fld_sel;
            name_reg <= node_name;
            last_reg <= last;
        end
        if (cmd.prep)
        begin
            a_reg <= mag32(corr_reg);
            h_reg <= h_diff[DATA_W] ? (~h_diff + (DATA_W+1)'(1)) : h_diff;
            f_reg <= mag32(fld_reg);
        end
        if (cmd.calc_ref)
        begin
            ref_reg  <= ref_next;
            a100_reg <= A100_W'(a_reg) * A100_W'(PCT_SCALE);
        end
        if (cmd.p_sat)
        begin
            p_reg <= {DATA_W{1'b1}};
        end
        else if (cmd.p_load)
        begin
            p_reg <= div_q[DATA_W-1:0];
        end
    end

    // Running statistics, cleared on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_abs_reg        <= '0;
            best_abs_node_reg   <= '1;
            sum_abs_reg         <= '0;
            count_abs_reg       <= '0;
            best_ratio_reg      <= '0;
            best_ratio_node_reg <= '1;
            sum_ratio_reg       <= '0;
            count_ratio_reg     <= '0;
        end
        else if (cmd.emit)
        begin
            best_abs_reg        <= '0;
            best_abs_node_reg   <= '1;
            sum_abs_reg         <= '0;
            count_abs_reg       <= '0;
            best_ratio_reg      <= '0;
            best_ratio_node_reg <= '1;
            sum_ratio_reg       <= '0;
            count_ratio_reg     <= '0;
        end
        else
        begin
            if (cmd.calc_ref)
            begin
                // sum and count stop at the count limit
                if (count_abs_reg != '1)
                begin
                    sum_abs_reg   <= sum_abs_reg + SUM_W'(a_reg);
                    count_abs_reg <= count_abs_reg + CNT_W'(1);
                end
                if (a_reg > best_abs_reg)
                begin
                    best_abs_reg      <= a_reg;
                    best_abs_node_reg <= {1'b0, name_reg};
                end
            end
            if (cmd.ratio_upd)
            begin
                if (count_ratio_reg != '1)
                begin
                    sum_ratio_reg   <= sum_ratio_reg + SUM_W'(p_reg);
                    count_ratio_reg <= count_ratio_reg + CNT_W'(1);
                end
                if (p_reg > best_ratio_reg)
                begin
                    best_ratio_reg      <= p_reg;
                    best_ratio_node_reg <= {1'b0, name_reg};
                end
            end
        end
    end

    // Divider operand select
    always_comb
    begin
        div_start = cmd.pct_start | cmd.avg_abs_start | cmd.avg_ratio_start;
        priority if (cmd.pct_start)
        begin
            div_rem   = DIV_W'(a100_reg);
            div_dvd   = '0;
            div_dsr   = ref_reg;
            div_steps = PCT_STEPS;
        end
        else if (cmd.avg_abs_start)
        begin
            div_rem   = '0;
            div_dvd   = {sum_abs_reg, {(DIV_W-SUM_W){1'b0}}};
            div_dsr   = DIV_W'(count_abs_reg);
            div_steps = AVG_STEPS;
        end
        else
        begin
            div_rem   = '0;
            div_dvd   = {sum_ratio_reg, {(DIV_W-SUM_W){1'b0}}};
            div_dsr   = DIV_W'(count_ratio_reg);
            div_steps = AVG_STEPS;
        end
    end

    ccs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    // Averages and result register
    always_ff @(posedge clk)
    begin
        if (cmd.avg_abs_store)
        begin
            avg_abs_q_reg <= (count_abs_reg == '0) ? '0 : sat_out(div_q);
        end
        if (cmd.avg_ratio_store)
        begin
            avg_ratio_q_reg <= (count_ratio_reg == '0) ? '0 : sat_out(div_q);
        end
        if (cmd.emit)
        begin
            max_abs_reg      <= sat_out(DIV_W'(best_abs_reg));
            max_abs_node_reg <= best_abs_node_reg;
            avg_abs_reg      <= avg_abs_q_reg;
            max_pct_reg      <= sat_out(DIV_W'(best_ratio_reg));
            max_pct_node_reg <= best_ratio_node_reg;
            avg_pct_reg      <= avg_ratio_q_reg;
        end
    end

    // Status to the controller
    always_comb
    begin
        status.ref_ok   = (ref_reg > REF_MIN);
        status.pct_sat  = (REF_W'(a100_reg) >= ref_reg);
        status.div_done = div_done;
        status.last     = last_reg;
    end

    assign max_abs      = max_abs_reg;
    assign max_abs_node = max_abs_node_reg;
    assign avg_abs      = avg_abs_reg;
    assign max_pct      = max_pct_reg;
    assign max_pct_node = max_pct_node_reg;
    assign avg_pct      = avg_pct_reg;

endmodule
